FILE: hw/rtl/huffman_tree_delta_sample_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tree delta sample decoder
// Shared wrappers so every check reports the same way.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DELTA_SAMPLE_DECODER_CORE_MACROS_SVH
`define HUFFMAN_TREE_DELTA_SAMPLE_DECODER_CORE_MACROS_SVH

// Consequent in the cycle after the antecedent, ignored in reset
`define HDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent in the same cycle as the antecedent, ignored in reset
`define HDC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after reset is seen
`define HDC_ASSERT_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/hdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree delta decoder package
// Types, widths and codes shared by the decoder modules.
// ----------------------------------------------------------------------------
package hdc_pkg;

   localparam int unsigned MAX_NODES_DEF = 256;
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned VALUE_W       = 7;
   localparam int unsigned LINK_W        = 10;
   localparam int unsigned COUNT_W       = 20;
   localparam int unsigned STK_ADDR_W    = 8;
   localparam logic [LINK_W-1:0] LINK_NONE = 10'h3FF;
   localparam logic [BYTE_W-1:0] SIGN_MASK = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              first_byte;
      logic              end_of_data;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sample;
      logic              last_sample;
   } rsp_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [LINK_W-1:0]  left;
      logic [LINK_W-1:0]  right;
   } node_word_type;

   typedef struct packed {
      logic rd;
      logic wr_value;
      logic wr_left;
      logic wr_right;
   } node_ctl_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } stack_ctl_type;

   typedef struct packed {
      logic                  has_right;
      logic [STK_ADDR_W-1:0] addr;
   } stack_entry_type;

   typedef enum logic [1:0] {
      PH_BUILD,
      PH_SIGN,
      PH_WALK,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_ROOT,
      ST_STEP,
      ST_POP,
      ST_POPW,
      ST_EMIT
   } state_type;

endpackage

FILE: hw/rtl/hdc_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// One beat moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface hdc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/hdc_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code tree memory
// One entry per node: value, left link, right link; per-field write enables,
// one address, registered read.
// ----------------------------------------------------------------------------
module hdc_node_mem #(
   parameter int unsigned MAX_NODES = hdc_pkg::MAX_NODES_DEF,
   localparam int unsigned AW = $clog2(MAX_NODES)
) (
   input  logic                  clock,
   input  hdc_pkg::node_ctl_type ctl,
   input  logic [AW-1:0]         addr,
   input  hdc_pkg::node_word_type wdata,
   output hdc_pkg::node_word_type rdata
);
   import hdc_pkg::*;

   logic [VALUE_W-1:0] value_mem [MAX_NODES];
   logic [LINK_W-1:0]  left_mem  [MAX_NODES];
   logic [LINK_W-1:0]  right_mem [MAX_NODES];
   node_word_type      rdata_ff;

   // write the enabled fields
   always_ff @(posedge clock) begin
      if (ctl.wr_value) begin
         value_mem[addr] <= wdata.value;
      end
      if (ctl.wr_left) begin
         left_mem[addr] <= wdata.left;
      end
      if (ctl.wr_right) begin
         right_mem[addr] <= wdata.right;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rdata_ff <= '{value: value_mem[addr], left: left_mem[addr], right: right_mem[addr]};
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/hdc_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Build stack memory
// Holds the pending right children of the pre-order tree build.
// ----------------------------------------------------------------------------
module hdc_stack_mem #(
   parameter int unsigned MAX_NODES = hdc_pkg::MAX_NODES_DEF,
   localparam int unsigned AW = $clog2(MAX_NODES)
) (
   input  logic                     clock,
   input  hdc_pkg::stack_ctl_type   ctl,
   input  logic [AW-1:0]            addr,
   input  hdc_pkg::stack_entry_type wdata,
   output hdc_pkg::stack_entry_type rdata
);
   import hdc_pkg::*;

   stack_entry_type stack_mem [MAX_NODES];
   stack_entry_type rdata_ff;

   // push
   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         stack_mem[addr] <= wdata;
      end
   end

   // pop read, registered
   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rdata_ff <= stack_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/hdc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder sequencer
// Steps through the bits of a byte: builds the tree into the node memory,
// then walks it per sample and hands each decoded sample out.
// ----------------------------------------------------------------------------
module hdc_seq #(
   parameter int unsigned MAX_NODES = hdc_pkg::MAX_NODES_DEF,
   localparam int unsigned AW = $clog2(MAX_NODES),
   localparam int unsigned CW = $clog2(MAX_NODES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_valid,
   output logic                          byte_ready,
   input  hdc_pkg::req_payload_type      byte_data,
   input  logic [hdc_pkg::COUNT_W-1:0]   sample_count,
   output logic                          emit_valid,
   input  logic                          emit_ready,
   output hdc_pkg::rsp_payload_type      emit_data,
   output hdc_pkg::node_ctl_type         node_ctl,
   output logic [AW-1:0]                 node_addr,
   output hdc_pkg::node_word_type        node_wdata,
   input  hdc_pkg::node_word_type        node_rdata,
   output hdc_pkg::stack_ctl_type        stack_ctl,
   output logic [AW-1:0]                 stack_addr,
   output hdc_pkg::stack_entry_type      stack_wdata,
   input  hdc_pkg::stack_entry_type      stack_rdata
);
   import hdc_pkg::*;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic [2:0]         bit_idx_ff, bit_idx_in;
   logic               eod_ff, eod_in;
   logic [3:0]         field_ff, field_in;
   logic [VALUE_W-1:0] partial_ff, partial_in;
   logic               has_left_ff, has_left_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [CW-1:0]      depth_ff, depth_in;
   logic               pop_oob_ff, pop_oob_in;
   node_word_type      cur_ff, cur_in;
   logic               pending_ff, pending_in;
   logic [BYTE_W-1:0]  delta_ff, delta_in;
   logic [BYTE_W-1:0]  running_ff, running_in;
   logic [COUNT_W-1:0] done_ff, done_in;
   rsp_payload_type    res_ff, res_in;

   logic               bit_w;
   logic               last_bit;
   logic               last_idx;
   logic               accept;
   logic [CW-1:0]      hdr_total;
   logic               room;
   logic [LINK_W-1:0]  walk_nxt;
   logic               nxt_oob;
   logic               step_end;
   logic               stop_due;
   logic [CW-1:0]      depth_m1;
   stack_entry_type    pop_e;
   logic               pop_a_oob;
   logic [BYTE_W-1:0]  end_base;
   logic [BYTE_W-1:0]  end_delta;
   logic [BYTE_W-1:0]  end_running;
   logic               hdr_pop;

   // shared decode of the current bit
   always_comb begin
      bit_w     = shift_ff[0];
      last_idx  = (bit_idx_ff == 3'd7);
      last_bit  = eod_ff && last_idx;
      accept    = byte_valid && byte_ready;
      hdr_total = total_ff + CW'(1);
      room      = hdr_total < CW'(MAX_NODES);
      walk_nxt  = bit_w ? cur_ff.right : cur_ff.left;
      nxt_oob   = walk_nxt >= LINK_W'(MAX_NODES);
      step_end  = last_bit || (node_rdata.left == LINK_NONE) || (node_rdata.right == LINK_NONE);
      stop_due  = done_ff >= sample_count;
      depth_m1  = depth_ff - CW'(1);
      pop_e     = pop_oob_ff ? '0 : stack_rdata;
      pop_a_oob = {1'b0, pop_e.addr} >= (STK_ADDR_W + 1)'(MAX_NODES);
      hdr_pop   = has_left_ff ? !room : !(bit_w && room);
      end_base  = (state_ff == ST_STEP) ? BYTE_W'(node_rdata.value) : delta_ff;
      end_delta = end_base ^ (pending_ff ? SIGN_MASK : '0);
      end_running = running_ff + end_delta;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            unique case (phase_ff)
               PH_BUILD: begin
                  if (field_ff == 4'd8 && hdr_pop) begin
                     state_in = ST_POP;
                  end else if (last_idx) begin
                     state_in = ST_IDLE;
                  end
               end
               PH_SIGN: begin
                  if (!stop_due) begin
                     state_in = ST_ROOT;
                  end else if (last_idx) begin
                     state_in = ST_IDLE;
                  end
               end
               PH_WALK: begin
                  state_in = nxt_oob ? ST_EMIT : ST_STEP;
               end
               PH_DONE: begin
                  if (last_idx) begin
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ROOT: state_in = last_idx ? ST_IDLE : ST_BIT;
         ST_STEP: begin
            if (step_end) begin
               state_in = ST_EMIT;
            end else begin
               state_in = last_idx ? ST_IDLE : ST_BIT;
            end
         end
         ST_POP: begin
            if (depth_ff == '0) begin
               state_in = last_idx ? ST_IDLE : ST_BIT;
            end else begin
               state_in = ST_POPW;
            end
         end
         ST_POPW: begin
            if (pop_e.has_right && total_ff < CW'(MAX_NODES)) begin
               state_in = last_idx ? ST_IDLE : ST_BIT;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_EMIT: begin
            if (emit_ready) begin
               state_in = last_idx ? ST_IDLE : ST_BIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      phase_in    = phase_ff;
      shift_in    = shift_ff;
      bit_idx_in  = bit_idx_ff;
      eod_in      = eod_ff;
      field_in    = field_ff;
      partial_in  = partial_ff;
      has_left_in = has_left_ff;
      total_in    = total_ff;
      depth_in    = depth_ff;
      pop_oob_in  = pop_oob_ff;
      cur_in      = cur_ff;
      pending_in  = pending_ff;
      delta_in    = delta_ff;
      running_in  = running_ff;
      done_in     = done_ff;
      res_in      = res_ff;
      node_ctl    = '0;
      node_addr   = total_ff[AW-1:0];
      node_wdata  = '{value: '0, left: LINK_NONE, right: LINK_NONE};
      stack_ctl   = '0;
      stack_addr  = depth_ff[AW-1:0];
      stack_wdata = '{has_right: bit_w, addr: STK_ADDR_W'(total_ff)};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               shift_in   = byte_data.in_byte;
               eod_in     = byte_data.end_of_data;
               bit_idx_in = '0;
               if (byte_data.first_byte) begin
                  phase_in   = PH_BUILD;
                  field_in   = '0;
                  partial_in = '0;
                  total_in   = '0;
                  depth_in   = '0;
                  pending_in = 1'b0;
                  delta_in   = '0;
                  running_in = '0;
                  done_in    = '0;
               end
            end
         end
         ST_BIT: begin
            unique case (phase_ff)
               PH_BUILD: begin
                  if (field_ff < 4'd7) begin
                     // collect the node value, store it on its seventh bit
                     partial_in[field_ff[2:0]] = bit_w;
                     field_in = field_ff + 4'd1;
                     if (field_ff == 4'd6) begin
                        partial_in = '0;
                        node_wdata.value = {bit_w, partial_ff[VALUE_W-2:0]};
                        node_ctl.wr_value = total_ff < CW'(MAX_NODES);
                     end
                  end else if (field_ff == 4'd7) begin
                     has_left_in = bit_w;
                     field_in    = 4'd8;
                  end else begin
                     // close the header: set links; with a left child, push the node and its right flag
                     field_in   = '0;
                     partial_in = '0;
                     total_in   = hdr_total;
                     node_ctl.wr_left  = 1'b1;
                     if (has_left_ff) begin
                        node_wdata.left = LINK_W'(hdr_total);
                        stack_ctl.wr = depth_ff < CW'(MAX_NODES);
                        depth_in     = depth_ff + CW'(1);
                     end else begin
                        node_ctl.wr_right = 1'b1;
                        if (bit_w) begin
                           node_wdata.right = LINK_W'(hdr_total);
                        end
                     end
                  end
               end
               PH_SIGN: begin
                  if (stop_due) begin
                     phase_in = PH_DONE;
                  end else begin
                     pending_in  = bit_w;
                     phase_in    = PH_WALK;
                     node_ctl.rd = 1'b1;
                     node_addr   = '0;
                  end
               end
               PH_WALK: begin
                  if (!nxt_oob) begin
                     node_ctl.rd = 1'b1;
                     node_addr   = walk_nxt[AW-1:0];
                  end
               end
               PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
         ST_ROOT: begin
            cur_in = node_rdata;
         end
         ST_STEP: begin
            delta_in = BYTE_W'(node_rdata.value);
            cur_in   = node_rdata;
         end
         ST_POP: begin
            if (depth_ff == '0) begin
               phase_in = PH_SIGN;
            end else begin
               depth_in      = depth_m1;
               pop_oob_in    = depth_m1 >= CW'(MAX_NODES);
               stack_ctl.rd  = 1'b1;
               stack_addr    = depth_m1[AW-1:0];
            end
         end
         ST_POPW: begin
            // resume the popped node's right child, or mark it empty
            node_ctl.wr_right = 1'b1;
            node_addr = pop_a_oob ? '0 : pop_e.addr[AW-1:0];
            if (pop_e.has_right) begin
               node_wdata.right = LINK_W'(total_ff);
               if (total_ff < CW'(MAX_NODES)) begin
                  field_in   = '0;
                  partial_in = '0;
               end
            end
         end
         ST_EMIT: begin
         end
         default: begin
         end
      endcase

      // close a sample: apply sign, accumulate, count
      if ((state_ff == ST_BIT && phase_ff == PH_WALK && nxt_oob) ||
          (state_ff == ST_STEP && step_end)) begin
         delta_in   = end_delta;
         running_in = end_running;
         res_in.sample = (done_ff != '0) ? end_running : '0;
         res_in.last_sample = ({1'b0, done_ff} + (COUNT_W + 1)'(1)) == {1'b0, sample_count};
         done_in    = done_ff + COUNT_W'(1);
         phase_in   = PH_SIGN;
      end

      // advance to the next bit once this one is finished
      if (state_in == ST_BIT || (state_in == ST_IDLE && state_ff != ST_IDLE)) begin
         if (state_ff != ST_IDLE) begin
            shift_in   = shift_ff >> 1;
            bit_idx_in = bit_idx_ff + 3'd1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_BUILD;
         field_ff   <= '0;
         partial_ff <= '0;
         total_ff   <= '0;
         depth_ff   <= '0;
         pending_ff <= 1'b0;
         delta_ff   <= '0;
         running_ff <= '0;
         done_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         field_ff   <= field_in;
         partial_ff <= partial_in;
         total_ff   <= total_in;
         depth_ff   <= depth_in;
         pending_ff <= pending_in;
         delta_ff   <= delta_in;
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      bit_idx_ff  <= bit_idx_in;
      eod_ff      <= eod_in;
      has_left_ff <= has_left_in;
      pop_oob_ff  <= pop_oob_in;
      cur_ff      <= cur_in;
      res_ff      <= res_in;
   end

   assign byte_ready = (state_ff == ST_IDLE);
   assign emit_valid = (state_ff == ST_EMIT);
   assign emit_data  = res_ff;

endmodule

FILE: hw/rtl/huffman_tree_delta_sample_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree delta sample decoder core
// Builds a pre-order code tree from the bit stream, then decodes delta coded
// samples by walking it, LSB first, up to four samples per byte.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload                         | accepted when
//  req_if  | in  | in_byte, first_byte, end_of_data     | valid && ready
//  rsp_if  | out | sample, last_sample                  | valid && ready
//  csr     | in  | csr_wr_data = sample_count           | csr_wr_en
//
// Steps: a byte is taken in ST_IDLE, then each bit gets an ST_BIT step while
// building (plus ST_POP and ST_POPW per stack pop and a closing ST_POP for the
// unwind after a header); a sign or walk bit that reads the node memory adds
// ST_ROOT or ST_STEP, each sample ST_EMIT; at most four two-bit samples a byte.
// Reset clears control state only; tree and stack memories are always written
// before they are read, so no clearing pass is run.
// A sample waits in the sequencer while the output register is full and not draining.
// ----------------------------------------------------------------------------
module huffman_tree_delta_sample_decoder_core #(
   parameter int unsigned MAX_NODES = hdc_pkg::MAX_NODES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   hdc_chan_if.sink                    req_if,
   hdc_chan_if.source                  rsp_if,
   input  logic                        csr_wr_en,
   input  logic [hdc_pkg::COUNT_W-1:0] csr_wr_data
);
   import hdc_pkg::*;

   localparam int unsigned AW = $clog2(MAX_NODES);

   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff;
   logic               emit_valid;
   logic               emit_ready;
   rsp_payload_type    emit_data;
   node_ctl_type       node_ctl;
   logic [AW-1:0]      node_addr;
   node_word_type      node_wdata;
   node_word_type      node_rdata;
   stack_ctl_type      stack_ctl;
   logic [AW-1:0]      stack_addr;
   stack_entry_type    stack_wdata;
   stack_entry_type    stack_rdata;

   hdc_seq #(.MAX_NODES(MAX_NODES)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_if.valid),
      .byte_ready   (req_if.ready),
      .byte_data    (req_if.payload),
      .sample_count (count_ff),
      .emit_valid   (emit_valid),
      .emit_ready   (emit_ready),
      .emit_data    (emit_data),
      .node_ctl     (node_ctl),
      .node_addr    (node_addr),
      .node_wdata   (node_wdata),
      .node_rdata   (node_rdata),
      .stack_ctl    (stack_ctl),
      .stack_addr   (stack_addr),
      .stack_wdata  (stack_wdata),
      .stack_rdata  (stack_rdata)
   );

   hdc_node_mem #(.MAX_NODES(MAX_NODES)) u_node_mem (
      .clock (clock),
      .ctl   (node_ctl),
      .addr  (node_addr),
      .wdata (node_wdata),
      .rdata (node_rdata)
   );

   hdc_stack_mem #(.MAX_NODES(MAX_NODES)) u_stack_mem (
      .clock (clock),
      .ctl   (stack_ctl),
      .addr  (stack_addr),
      .wdata (stack_wdata),
      .rdata (stack_rdata)
   );

   // sample count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // output register: load when empty or draining
   assign emit_ready = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid && emit_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid && emit_ready) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule

FILE: hw/rtl/hdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder port checker
// Watches the channel ports of the decoder core over time.
// ----------------------------------------------------------------------------
`include "huffman_tree_delta_sample_decoder_core_macros.svh"

module hdc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input hdc_pkg::rsp_payload_type rsp_payload
);
   import hdc_pkg::*;

   // an accepted byte drops ready while its bits are worked
   `HDC_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && req_ready, !req_ready, "byte accepted while previous byte still in progress")

   // a stalled result holds
   `HDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result dropped or changed")

   // a new result comes only from a byte in progress
   `HDC_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), !$past(req_ready), "result appeared without a byte in progress")

   // reset leaves the block empty and ready
   `HDC_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid && req_ready, "block not empty and ready after reset")

endmodule

bind huffman_tree_delta_sample_decoder_core hdc_checker u_hdc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

FILE: verif/hdc_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample stream checker for the tree delta sample decoder
// Watches the byte and sample channels and the count register, keeps its own
// copy of the tree builder and walker, and compares every sample beat against
// the oldest predicted sample.
// ----------------------------------------------------------------------------
module hdc_sample_checker #(
   parameter int unsigned MAX_NODES = hdc_pkg::MAX_NODES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  hdc_pkg::req_payload_type     req_beat,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  hdc_pkg::rsp_payload_type     rsp_beat,
   input  logic                         csr_wr_en,
   input  logic [hdc_pkg::COUNT_W-1:0]  csr_wr_data,
   output int unsigned                  mismatch_count,
   output int unsigned                  samples_owed
);
   import hdc_pkg::*;

   // Tree and build state
   logic [VALUE_W-1:0] tree_value [MAX_NODES];
   logic [LINK_W-1:0]  tree_left  [MAX_NODES];
   logic [LINK_W-1:0]  tree_right [MAX_NODES];
   stack_entry_type    pend_stack [MAX_NODES];
   int unsigned        depth;
   int unsigned        nodes;
   phase_type          ph;
   int unsigned        walk_node;
   logic               sign_bit;
   logic [7:0]         delta;
   logic [7:0]         acc;
   logic [COUNT_W-1:0] produced;
   logic [COUNT_W-1:0] count_limit;
   logic [6:0]         field;
   int unsigned        field_n;
   rsp_payload_type    sample_q [$];

   task automatic clear_decoder();
      for (int i = 0; i < MAX_NODES; i++) begin
         tree_value[i] = '0;
         tree_left[i]  = '0;
         tree_right[i] = '0;
         pend_stack[i] = '0;
      end
      depth     = 0;
      nodes     = 0;
      ph        = PH_BUILD;
      walk_node = 0;
      sign_bit  = 1'b0;
      delta     = '0;
      acc       = '0;
      produced  = '0;
      field     = '0;
      field_n   = 0;
   endtask

   // True when a child header has to be read next
   function automatic bit open_child();
      if (nodes >= MAX_NODES) return 1'b0;
      field_n = 0;
      field   = '0;
      return 1'b1;
   endfunction

   // Resume pending right children, or hand over to decoding
   task automatic unwind_stack();
      stack_entry_type e;
      int unsigned     a;
      forever begin
         if (depth == 0) begin
            ph = PH_SIGN;
            return;
         end
         depth--;
         e = (depth < MAX_NODES) ? pend_stack[depth] : '0;
         a = e.addr;
         if (a >= MAX_NODES) a = 0;
         if (e.has_right) begin
            tree_right[a] = LINK_W'(nodes);
            if (open_child()) return;
         end else begin
            tree_right[a] = LINK_NONE;
         end
      end
   endtask

   task automatic close_header(input logic hl, input logic hr);
      int unsigned a;
      a = (nodes >= MAX_NODES) ? MAX_NODES - 1 : nodes;
      nodes++;
      if (hl) begin
         tree_left[a] = LINK_W'(nodes);
         if (depth < MAX_NODES) pend_stack[depth] = '{has_right: hr, addr: a[7:0]};
         depth++;
         if (open_child()) return;
         unwind_stack();
         return;
      end
      tree_left[a] = LINK_NONE;
      if (hr) begin
         tree_right[a] = LINK_W'(nodes);
         if (open_child()) return;
      end else begin
         tree_right[a] = LINK_NONE;
      end
      unwind_stack();
   endtask

   task automatic take_tree_bit(input logic b);
      logic hl;
      if (field_n < 7) begin
         field[field_n] = b;
         field_n++;
         if (field_n == 7) begin
            if (nodes < MAX_NODES) tree_value[nodes] = field;
            field = '0;
         end
      end else if (field_n == 7) begin
         field   = {6'd0, b};
         field_n = 8;
      end else begin
         hl      = field[0];
         field_n = 0;
         field   = '0;
         close_header(hl, b);
      end
   endtask

   // Apply sign, accumulate and queue the sample
   task automatic emit_sample();
      rsp_payload_type s;
      if (sign_bit) delta ^= SIGN_MASK;
      acc           = acc + delta;
      s.sample      = (produced != 0) ? acc : 8'd0;
      s.last_sample = ({1'b0, produced} + 21'd1) == {1'b0, count_limit};
      sample_q.push_back(s);
      produced = produced + 1'b1;
      ph       = PH_SIGN;
   endtask

   task automatic take_sample_bit(input logic b, input logic last_bit);
      int unsigned cur;
      logic [LINK_W-1:0] nxt;
      if (ph == PH_SIGN) begin
         if (produced >= count_limit) begin
            ph = PH_DONE;
            return;
         end
         sign_bit  = b;
         walk_node = 0;
         ph        = PH_WALK;
         return;
      end
      cur = (walk_node < MAX_NODES) ? walk_node : 0;
      nxt = b ? tree_right[cur] : tree_left[cur];
      if (nxt >= MAX_NODES) begin
         emit_sample();
         return;
      end
      delta = {1'b0, tree_value[nxt]};
      if (last_bit || tree_left[nxt] == LINK_NONE || tree_right[nxt] == LINK_NONE) begin
         emit_sample();
         return;
      end
      walk_node = nxt;
   endtask

   // Track register writes, predict on byte beats, compare on sample beats
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         clear_decoder();
         count_limit    = '0;
         mismatch_count = 0;
         sample_q.delete();
      end else begin
         if (csr_wr_en) count_limit = csr_wr_data;
         if (req_valid && req_ready) begin
            if (req_beat.first_byte) clear_decoder();
            for (int i = 0; i < 8; i++) begin
               if (ph == PH_BUILD)
                  take_tree_bit(req_beat.in_byte[i]);
               else if (ph == PH_SIGN || ph == PH_WALK)
                  take_sample_bit(req_beat.in_byte[i], req_beat.end_of_data && i == 7);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (sample_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected sample beat %02h last %0b", $realtime,
                           rsp_beat.sample, rsp_beat.last_sample);
            end else begin
               want = sample_q.pop_front();
               if (want.sample !== rsp_beat.sample || want.last_sample !== rsp_beat.last_sample)
               begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: sample exp %02h last %0b, got %02h last %0b", $realtime,
                              want.sample, want.last_sample, rsp_beat.sample,
                              rsp_beat.last_sample);
               end
            end
         end
      end
      samples_owed = sample_q.size();
   end

endmodule

FILE: verif/huffman_tree_delta_sample_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree delta sample decoder testbench
// Sends well-formed compressed streams (random pre-order trees, random walk
// bits, pad bytes) and some noise through the byte channel under varying
// back-pressure and count settings; the checker predicts every sample.
// ----------------------------------------------------------------------------
module huffman_tree_delta_sample_decoder_core_tb;
   import hdc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE      = 1200;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [COUNT_W-1:0]  csr_wr_data;
   int unsigned         mismatch_count;
   int unsigned         samples_owed;
   int unsigned         send_idle_pct;
   int unsigned         recv_idle_pct;
   bit                  hold_off_req;
   int unsigned         cycles;
   int unsigned         mode_bytes;
   bit                  stream_bits [$];

   hdc_chan_if #(.payload_type(req_payload_type)) req_if ();
   hdc_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   huffman_tree_delta_sample_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if.sink),
      .rsp_if      (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hdc_sample_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_beat       (req_if.payload),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_beat       (rsp_if.payload),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .samples_owed   (samples_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Sample side: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !reset) begin
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_if.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one byte beat and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic fb, input logic eod);
      req_payload_type p;
      p = '{in_byte: b, first_byte: fb, end_of_data: eod};
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      mode_bytes++;
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Drain all samples, then let a long unwind finish
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (samples_owed != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_field(input int unsigned v, input int unsigned w);
      for (int i = 0; i < w; i++) stream_bits.push_back(v[i]);
   endtask

   // Build a pre-order tree header stream; full fills all node slots
   task automatic make_tree(input int unsigned want, input bit full);
      int unsigned pending;
      int unsigned made;
      bit hl;
      bit hr;
      pending = 1;
      made    = 0;
      while (pending > 0 && !(full && made == MAX_NODES_DEF)) begin
         push_field($urandom_range(127), VALUE_W);
         pending--;
         made++;
         if (!full && made >= want) begin
            hl = 1'b0;
            hr = 1'b0;
         end else begin
            hl = 1'($urandom_range(1));
            hr = 1'($urandom_range(1));
            if (pending == 0 && !hl && !hr) begin
               if ($urandom_range(1)) hl = 1'b1;
               else hr = 1'b1;
            end
         end
         pending += hl + hr;
         stream_bits.push_back(hl);
         stream_bits.push_back(hr);
      end
   endtask

   // Pack the queued bits LSB first, flag the last real byte, append pads
   task automatic send_stream(input bit fresh, input int unsigned pads);
      int unsigned n;
      logic [7:0]  b;
      while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'b0);
      n = stream_bits.size() / 8;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 8; i++) b[i] = stream_bits.pop_front();
         send_byte(b, fresh && k == 0, k == n - 1);
      end
      repeat (pads) send_byte(8'h00, 1'b0, 1'b1);
   endtask

   task automatic tree_stream(input int unsigned want, input bit full,
                              input int unsigned walk_bits, input int unsigned pads);
      stream_bits.delete();
      make_tree(want, full);
      for (int i = 0; i < walk_bits; i++) stream_bits.push_back(1'($urandom_range(1)));
      send_stream(1'b1, pads);
   endtask

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_if.valid  = 1'b0;
      req_if.payload = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req  = 1'b0;
      mode_bytes    = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: small tree, noise extremes, zero count, top count
      write_count(20'd3);
      tree_stream(3, 1'b0, 24, 1);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      wait_idle();
      write_count(20'd0);
      tree_stream(4, 1'b0, 20, 1);
      wait_idle();
      write_count(20'hFFFFF);
      tree_stream(5, 1'b0, 40, 2);
      wait_idle();
      // Lowered count: carry on the same stream without a fresh first byte
      write_count(20'd1);
      stream_bits.delete();
      for (int i = 0; i < 24; i++) stream_bits.push_back(1'($urandom_range(1)));
      send_stream(1'b0, 0);
      wait_idle();

      // Random: three idling patterns
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 71 : 0;
         recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 6 : 0;
         mode_bytes    = 0;
         write_count(($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(1, 14)));
         if (mode == 0) hold_off_req = 1'b1;
         while (mode_bytes < 35) begin
            if ($urandom_range(99) < 85) begin
               tree_stream($urandom_range(1, 12), 1'b0, $urandom_range(4, 60),
                           $urandom_range(2));
            end else begin
               repeat ($urandom_range(1, 4))
                  send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
            end
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
